// ===== design/rtufdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtufdc_pkg
// Types, constants and the CRC-16/MODBUS byte update for the RTU frame
// delimiter.
// ----------------------------------------------------------------------------
package rtufdc_pkg;

  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPolyRefl  = 16'hA001;  // 0x8005 bit-reversed
  localparam logic [15:0] GapReset     = 16'd1750;
  localparam logic [15:0] IdleMax      = 16'hFFFF;
  localparam logic [8:0]  LenFixed     = 9'd8;
  localparam logic [9:0]  LenWrBase    = 10'd9;
  localparam logic [8:0]  LenMin       = 9'd4;
  localparam logic [8:0]  PosFunc      = 9'd1;
  localparam logic [8:0]  PosByteCnt   = 9'd6;

  typedef enum logic [7:0] {
    FC_READ_HOLD  = 8'd3,
    FC_READ_INPUT = 8'd4,
    FC_WRITE_ONE  = 8'd6,
    FC_WRITE_MULT = 8'd16
  } func_code_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_PROGRESS = 3'd0,
    ST_GOOD     = 3'd1,
    ST_BAD_CRC  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_LEN_LONG = 3'd4
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [8:0]  frame_length;
    logic [8:0]  byte_position;
    logic [7:0]  byte_out;
  } result_t;

  // reflected crc over one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPolyRefl;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/rtu_frame_delimiter_crc_check_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtu_frame_delimiter_crc_check_core
// Modbus RTU request delimiter: forwards bytes with their frame position and
// closes frames by function-code length, silence gap or abort, with CRC check.
// ----------------------------------------------------------------------------
// One request (a byte or a time tick) is taken per clock. All frame tracking
// and the CRC-16/MODBUS update of a byte happen in the cycle of acceptance,
// and the result lands in a single output register, so a new request is
// accepted every cycle while the output side takes results; a stalled result
// holds only the request that would replace it. Ticks with no frame open, and
// ticks short of the gap, give no result. The gap register is written with
// cfg_we_i and should change only while the block is idle.
module rtu_frame_delimiter_crc_check_core #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // gap_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // byte_out [7:0], byte_position [16:8], frame_length [25:17], status [28:26]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast    // frame_end
);

  localparam logic [9:0] MaxBytes = 10'(MAX_FRAME_BYTES);

  logic [15:0] gap_q;
  logic [8:0]  cnt_q, cnt_d;
  logic [7:0]  fc_q, fc_d;
  logic [8:0]  exp_q, exp_d;
  logic        known_q, known_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] idle_q, idle_d;

  logic                 out_vld_q;
  logic                 out_bv_q, out_bv_d;
  logic                 out_end_q, out_end_d;
  rtufdc_pkg::result_t  out_res_q, out_res_d;
  logic                 res_gen;

  logic        accept;
  logic [15:0] limit;
  logic [15:0] idle_inc;
  logic [15:0] crc_n;
  logic [9:0]  cnt_n;
  logic [9:0]  exp_n;
  logic        known_n;
  logic        frame_close;
  logic        good;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign limit         = (gap_q == 16'd0) ? 16'd1 : gap_q;
  assign idle_inc      = (idle_q == rtufdc_pkg::IdleMax) ? idle_q : idle_q + 16'd1;
  assign crc_n         = rtufdc_pkg::crc_byte(crc_q, s_axis_tdata);
  assign cnt_n         = {1'b0, cnt_q} + 10'd1;

  always_comb begin
    cnt_d       = cnt_q;
    fc_d        = fc_q;
    exp_d       = exp_q;
    known_d     = known_q;
    crc_d       = crc_q;
    idle_d      = idle_q;
    res_gen     = 1'b0;
    out_bv_d    = 1'b0;
    out_end_d   = 1'b0;
    out_res_d   = '{status: rtufdc_pkg::ST_PROGRESS, frame_length: 9'd0,
                    byte_position: 9'd0, byte_out: 8'd0};
    exp_n       = {1'b0, exp_q};
    known_n     = known_q;
    frame_close = 1'b0;
    good        = 1'b0;

    if (accept) begin
      if (s_axis_tuser == rtufdc_pkg::CMD_TICK) begin
        if (cnt_q != 9'd0) begin
          idle_d = idle_inc;
          if (idle_inc >= limit) begin
            good                   = (cnt_q >= rtufdc_pkg::LenMin) && (crc_q == 16'd0);
            res_gen                = 1'b1;
            out_end_d              = 1'b1;
            out_res_d.frame_length = cnt_q;
            out_res_d.status       = good ? rtufdc_pkg::ST_GOOD : rtufdc_pkg::ST_BAD_CRC;
            frame_close            = 1'b1;
          end
        end
      end else begin
        res_gen                 = 1'b1;
        out_bv_d                = 1'b1;
        out_res_d.byte_out      = s_axis_tdata;
        out_res_d.byte_position = cnt_q;
        idle_d                  = 16'd0;
        crc_d                   = crc_n;
        cnt_d                   = cnt_n[8:0];

        if (cnt_q == rtufdc_pkg::PosFunc) begin
          fc_d = s_axis_tdata;
          if (s_axis_tdata inside {rtufdc_pkg::FC_READ_HOLD, rtufdc_pkg::FC_READ_INPUT,
                                   rtufdc_pkg::FC_WRITE_ONE}) begin
            exp_n   = {1'b0, rtufdc_pkg::LenFixed};
            known_n = 1'b1;
          end
        end else if (cnt_q == rtufdc_pkg::PosByteCnt &&
                     fc_q == rtufdc_pkg::FC_WRITE_MULT) begin
          exp_n   = rtufdc_pkg::LenWrBase + {2'b00, s_axis_tdata};
          known_n = 1'b1;
        end
        exp_d   = exp_n[8:0];
        known_d = known_n;

        // declared length beyond capacity aborts right on the byte-count byte
        if (cnt_q == rtufdc_pkg::PosByteCnt && fc_q == rtufdc_pkg::FC_WRITE_MULT &&
            exp_n > MaxBytes) begin
          out_end_d              = 1'b1;
          out_res_d.frame_length = cnt_n[8:0];
          out_res_d.status       = rtufdc_pkg::ST_LEN_LONG;
          frame_close            = 1'b1;
        end else if (known_n) begin
          if (cnt_n >= exp_n) begin
            good                   = (cnt_n >= {1'b0, rtufdc_pkg::LenMin}) && (crc_n == 16'd0);
            out_end_d              = 1'b1;
            out_res_d.frame_length = cnt_n[8:0];
            out_res_d.status       = good ? rtufdc_pkg::ST_GOOD : rtufdc_pkg::ST_BAD_CRC;
            frame_close            = 1'b1;
          end
        end else if (cnt_n > MaxBytes) begin
          out_end_d              = 1'b1;
          out_res_d.frame_length = cnt_n[8:0];
          out_res_d.status       = rtufdc_pkg::ST_OVERFLOW;
          frame_close            = 1'b1;
        end
      end

      if (frame_close) begin
        cnt_d   = 9'd0;
        fc_d    = 8'd0;
        exp_d   = 9'd0;
        known_d = 1'b0;
        crc_d   = rtufdc_pkg::CrcInit;
        idle_d  = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q   <= rtufdc_pkg::GapReset;
      cnt_q   <= 9'd0;
      fc_q    <= 8'd0;
      exp_q   <= 9'd0;
      known_q <= 1'b0;
      crc_q   <= rtufdc_pkg::CrcInit;
      idle_q  <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        gap_q <= cfg_wdata_i;
      end
      cnt_q   <= cnt_d;
      fc_q    <= fc_d;
      exp_q   <= exp_d;
      known_q <= known_d;
      crc_q   <= crc_d;
      idle_q  <= idle_d;
    end
  end

  // output register: loads on a new result, empties when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_vld_q <= res_gen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && res_gen) begin
      out_bv_q  <= out_bv_d;
      out_end_q <= out_end_d;
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_res_q};
  assign m_axis_tuser  = out_bv_q;
  assign m_axis_tlast  = out_end_q;

  // frame count never passes the capacity, overflow closes it first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= MaxBytes)
    else $error("byte count beyond frame capacity");

  // a known length always lies ahead of the bytes seen so far
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    known_q |-> (exp_q > cnt_q))
    else $error("known frame length already reached");

  // idle ticks only count while a frame is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_q != 16'd0) |-> (cnt_q != 9'd0))
    else $error("idle count with no frame open");

  // a result without a byte must close a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
    else $error("empty result that does not end a frame");

  // a fresh request with a stalled output must not be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request accepted while result is stalled");

endmodule
